/* hdl/bwt_pkg.sv */
// Package for the block decoder: func and status codes, block size, command and status structs.
// No dependencies.
package bwt_pkg;

   localparam logic [1:0] FUNC_LOAD    = 2'd0;
   localparam logic [1:0] FUNC_TRAILER = 2'd1;
   localparam logic [1:0] FUNC_FETCH   = 2'd2;

   localparam logic [1:0] ST_BYTE     = 2'd0;
   localparam logic [1:0] ST_NONE     = 2'd1;
   localparam logic [1:0] ST_BAD_IDX  = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   localparam int NSYM     = 257;
   localparam int SENT_SYM = 256;

   localparam int MAX_BLOCK = 4096;
   localparam int AW        = 12;
   localparam int CW        = 13;

   typedef struct packed {
      logic load;       // write byte at loaded_count
      logic restart;    // clear loaded_count before load
      logic clr_load;   // loaded_count := 0
      logic trailer;    // latch start/end rows, clear emitted count
      logic cnt_start;  // begin counting pass
      logic fetch;      // read column and link at cursor
      logic step;       // advance cursor, count emitted
   } cmd_type;

   typedef struct packed {
      logic full;        // loaded_count >= MAX_BLOCK
      logic bad_rows;    // trailer rows out of range
      logic short_blk;   // loaded_count <= 1
      logic build_done;  // link table finished
      logic walk_ok;     // a byte may be given
      logic last;        // next byte is the last
   } sts_type;

endpackage

/* hdl/bwt_block_decoder_top.sv */
// Loads: no result unless the block is full (overflow). Fetch: result registered after the
// S_FETCH state, busy during S_FETCH. Errors and "nothing ready": result the cycle after
// accept. Trailer: busy while the symbol counting, prefix sum and link fill passes run.
// Synchronous reset empties the block, then busy stays high while the symbol counters
// clear; the column and link stores hold no reset value.
// Results are strobed for one cycle; the receiver cannot stall.
// Top level of the block decoder; instantiates bwt_ctrl and bwt_datapath, uses bwt_pkg.
module bwt_block_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_byte_value,
   input  logic [11:0] req_start_row,
   input  logic [11:0] req_sentinel_row,
   output logic        rsp_valid,
   output logic [7:0]  rsp_out_byte,
   output logic [1:0]  rsp_status,
   output logic        rsp_last_of_block
);
   import bwt_pkg::*;

   cmd_type    cmd;
   sts_type    sts;
   logic [7:0] rd_byte;
   logic       use_byte;

   bwt_ctrl u_ctrl (
      .clock, .reset, .start, .req_func, .sts, .cmd, .busy,
      .rsp_valid, .rsp_status, .rsp_last_of_block, .rsp_use_byte(use_byte)
   );

   bwt_datapath u_dp (
      .clock, .reset, .cmd,
      .byte_value(req_byte_value), .start_row(req_start_row),
      .sentinel_row(req_sentinel_row), .sts, .rd_byte
   );

   assign rsp_out_byte = use_byte ? rd_byte : 8'd0;
endmodule

/* hdl/bwt_datapath.sv */
// Datapath: column store, link table, symbol counters, link build passes and walk.
// Depends on bwt_pkg.
module bwt_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  bwt_pkg::cmd_type     cmd,
   input  logic [7:0]           byte_value,
   input  logic [11:0]          start_row,
   input  logic [11:0]          sentinel_row,
   output bwt_pkg::sts_type     sts,
   output logic [7:0]           rd_byte
);
   import bwt_pkg::*;

   typedef enum logic [4:0] {
      B_IDLE  = 5'b00001,
      B_COUNT = 5'b00010,
      B_SUM   = 5'b00100,
      B_FILL  = 5'b01000,
      B_DONE  = 5'b10000
   } bstate_type;

   logic [7:0]    col_mem [MAX_BLOCK];
   logic [AW-1:0] link_mem [MAX_BLOCK];
   logic [CW-1:0] cnt_mem [NSYM];
   logic [CW-1:0] bkt_mem [NSYM];

   logic [CW-1:0] loaded_ff, loaded_in;
   logic [CW-1:0] emitted_ff, emitted_in;
   logic [11:0]   cursor_ff, cursor_in;
   logic [11:0]   end_row_ff;
   bstate_type    bst_ff, bst_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] sum_ff, sum_in;
   logic [8:0]    sidx_ff, sidx_in;
   logic [CW-1:0] rd_col_addr;
   logic [7:0]    col_q;
   logic          fetch_ff;

   // column read address shared between build passes and fetch
   always_comb begin
      rd_col_addr = idx_ff;
      if (cmd.fetch)
         rd_col_addr = CW'(cursor_ff);
   end

   // sym of row pidx_ff: registered col read then sentinel compare
   logic [CW-1:0] pidx_ff;
   logic          pvalid_ff;
   logic [8:0]    psym;
   always_comb psym = (pidx_ff[11:0] == end_row_ff && pidx_ff < CW'(4096)) ?
                      9'(SENT_SYM) : {1'b0, col_q};

   always_ff @(posedge clock) begin
      if (cmd.load)
         col_mem[loaded_in[AW-1:0] - AW'(1)] <= byte_value;
      col_q <= col_mem[rd_col_addr[AW-1:0]];
   end

   // counting and fill: registered counter read, then write back in the cycle after;
   // a same-symbol row right behind takes the value just written
   logic [CW-1:0] qidx_ff;
   logic [8:0]    qsym_ff;
   logic          qvalid_ff;
   logic [CW-1:0] cnt_rd_ff, bkt_rd_ff;
   logic [8:0]    cnt_raddr;
   logic          svalid_ff;
   logic [8:0]    ssidx_ff;
   logic          wvalid_ff;
   logic [8:0]    wsym_ff;
   logic [CW-1:0] wval_ff, wval_in;
   logic          fwd;
   logic [CW-1:0] cval, bval;

   always_comb begin
      cnt_raddr = (bst_ff == B_SUM) ? sidx_ff : psym;
      fwd       = wvalid_ff && wsym_ff == qsym_ff;
      cval      = fwd ? wval_ff : cnt_rd_ff;
      bval      = fwd ? wval_ff : bkt_rd_ff;
      wval_in   = ((bst_ff == B_COUNT) ? cval : bval) + CW'(1);
   end

   always_ff @(posedge clock) begin
      cnt_rd_ff <= cnt_mem[cnt_raddr];
      bkt_rd_ff <= bkt_mem[psym];
      if (svalid_ff) begin
         bkt_mem[ssidx_ff] <= sum_ff;
         cnt_mem[ssidx_ff] <= '0;
      end else if (qvalid_ff && bst_ff == B_COUNT) begin
         cnt_mem[qsym_ff] <= wval_in;
      end else if (qvalid_ff && bst_ff == B_FILL) begin
         bkt_mem[qsym_ff] <= wval_in;
         if (bval < CW'(MAX_BLOCK))
            link_mem[bval[AW-1:0]] <= qidx_ff[AW-1:0];
      end
   end

   logic [AW-1:0] link_q;
   always_ff @(posedge clock) begin
      link_q   <= link_mem[cursor_ff[AW-1:0]];
      rd_byte  <= col_mem[cursor_ff[AW-1:0]];
   end

   always_comb begin
      bst_in  = bst_ff;
      idx_in  = idx_ff;
      sum_in  = sum_ff;
      sidx_in = sidx_ff;
      if (svalid_ff)
         sum_in = sum_ff + cnt_rd_ff;
      case (bst_ff)
         B_IDLE: begin
            if (cmd.cnt_start) begin
               bst_in = B_COUNT;
               idx_in = '0;
            end
         end
         B_COUNT: begin
            if (idx_ff < loaded_ff)
               idx_in = idx_ff + CW'(1);
            else if (!pvalid_ff && !qvalid_ff) begin
               bst_in  = B_SUM;
               sidx_in = '0;
               sum_in  = '0;
            end
         end
         B_SUM: begin
            sidx_in = sidx_ff + 9'd1;
            if (sidx_ff == 9'(NSYM - 1)) begin
               bst_in = B_FILL;
               idx_in = '0;
            end
         end
         B_FILL: begin
            if (idx_ff < loaded_ff)
               idx_in = idx_ff + CW'(1);
            else if (!pvalid_ff && !qvalid_ff)
               bst_in = B_DONE;
         end
         B_DONE: bst_in = B_IDLE;
         default: bst_in = B_IDLE;
      endcase
   end

   always_comb begin
      loaded_in = loaded_ff;
      if (cmd.restart || cmd.clr_load)
         loaded_in = '0;
      if (cmd.load)
         loaded_in = loaded_in + CW'(1);
      emitted_in = emitted_ff;
      cursor_in  = cursor_ff;
      if (cmd.trailer) begin
         emitted_in = '0;
         cursor_in  = start_row;
      end
      if (cmd.step) begin
         emitted_in = emitted_ff + CW'(1);
         cursor_in  = 12'(link_q);
      end
   end

   // reset starts a prefix-sum pass so that every counter is cleared
   always_ff @(posedge clock) begin
      if (reset) begin
         bst_ff     <= B_SUM;
         sidx_ff    <= '0;
         sum_ff     <= '0;
         loaded_ff  <= '0;
         emitted_ff <= '0;
         cursor_ff  <= '0;
         end_row_ff <= '0;
         pvalid_ff  <= 1'b0;
         qvalid_ff  <= 1'b0;
         wvalid_ff  <= 1'b0;
         svalid_ff  <= 1'b0;
         fetch_ff   <= 1'b0;
      end else begin
         bst_ff     <= bst_in;
         sidx_ff    <= sidx_in;
         sum_ff     <= sum_in;
         loaded_ff  <= loaded_in;
         emitted_ff <= emitted_in;
         cursor_ff  <= cursor_in;
         if (cmd.trailer)
            end_row_ff <= sentinel_row;
         pvalid_ff  <= (bst_ff == B_COUNT || bst_ff == B_FILL) && idx_ff < loaded_ff;
         qvalid_ff  <= pvalid_ff;
         wvalid_ff  <= qvalid_ff;
         svalid_ff  <= bst_ff == B_SUM;
         fetch_ff   <= cmd.fetch;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      pidx_ff  <= idx_ff;
      qidx_ff  <= pidx_ff;
      qsym_ff  <= psym;
      ssidx_ff <= sidx_ff;
      wsym_ff  <= qsym_ff;
      wval_ff  <= wval_in;
   end

   always_comb begin
      sts.full       = loaded_ff >= CW'(MAX_BLOCK);
      sts.bad_rows   = CW'(start_row) >= loaded_ff || CW'(sentinel_row) >= loaded_ff;
      sts.short_blk  = loaded_ff <= CW'(1);
      sts.build_done = bst_ff == B_DONE;
      sts.walk_ok    = loaded_ff >= CW'(2) && emitted_ff < loaded_ff - CW'(1) &&
                       CW'(cursor_ff) < CW'(MAX_BLOCK);
      sts.last       = emitted_ff + CW'(1) == loaded_ff - CW'(1);
   end

   a_step_after_fetch: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> fetch_ff) else $error("step without fetch");
   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      bst_ff == B_FILL |-> idx_ff <= loaded_ff) else $error("fill index overrun");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> bst_ff == B_IDLE) else $error("load during build");
endmodule

/* hdl/bwt_ctrl.sv */
// Controller: accepts items, sequences the link build and the fetch, forms results.
// Depends on bwt_pkg.
module bwt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [1:0]       req_func,
   input  bwt_pkg::sts_type sts,
   output bwt_pkg::cmd_type cmd,
   output logic             busy,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic             rsp_last_of_block,
   output logic             rsp_use_byte
);
   import bwt_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_BUILD = 4'b0010,
      S_FETCH = 4'b0100,
      S_STEP  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      decoding_ff, decoding_in;
   logic      last_ff, last_in;
   logic      rv_ff, rv_in;
   logic [1:0] rs_ff, rs_in;
   logic      rl_ff, rl_in;
   logic      acc;

   assign acc  = start && !busy;
   assign busy = state_ff != S_IDLE;

   always_comb begin
      state_in    = state_ff;
      decoding_in = decoding_ff;
      last_in     = last_ff;
      rv_in = 1'b0; rs_in = ST_BYTE; rl_in = 1'b0;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (acc) begin
               case (req_func)
                  FUNC_LOAD: begin
                     if (decoding_ff) begin
                        cmd.restart = 1'b1;
                        decoding_in = 1'b0;
                        cmd.load    = 1'b1;
                     end else if (sts.full) begin
                        rv_in = 1'b1; rs_in = ST_OVERFLOW;
                     end else
                        cmd.load = 1'b1;
                  end
                  FUNC_TRAILER: begin
                     if (sts.bad_rows) begin
                        cmd.clr_load = 1'b1;
                        decoding_in  = 1'b0;
                        rv_in = 1'b1; rs_in = ST_BAD_IDX;
                     end else begin
                        cmd.trailer   = 1'b1;
                        cmd.cnt_start = 1'b1;
                        state_in      = S_BUILD;
                     end
                  end
                  FUNC_FETCH: begin
                     if (decoding_ff && sts.walk_ok) begin
                        cmd.fetch = 1'b1;
                        last_in   = sts.last;
                        state_in  = S_FETCH;
                     end else begin
                        rv_in = 1'b1; rs_in = ST_NONE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_BUILD: begin
            if (sts.build_done) begin
               state_in = S_IDLE;
               if (sts.short_blk) begin
                  cmd.clr_load = 1'b1;
                  decoding_in  = 1'b0;
               end else
                  decoding_in = 1'b1;
            end
         end
         S_FETCH: begin
            cmd.step = 1'b1;
            rv_in = 1'b1; rs_in = ST_BYTE; rl_in = last_ff;
            if (last_ff) begin
               cmd.clr_load = 1'b1;
               decoding_in  = 1'b0;
            end
            state_in = S_IDLE;
         end
         S_STEP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // after reset, wait in S_BUILD for the counter clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_BUILD;
         decoding_ff <= 1'b0;
         last_ff     <= 1'b0;
         rv_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         decoding_ff <= decoding_in;
         last_ff     <= last_in;
         rv_ff       <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      rs_ff <= rs_in;
      rl_ff <= rl_in;
   end

   assign rsp_valid         = rv_ff;
   assign rsp_status        = rs_ff;
   assign rsp_last_of_block = rl_ff;
   assign rsp_use_byte      = rv_ff && rs_ff == ST_BYTE;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !cmd.load && !cmd.trailer) else $error("item taken while busy");
   a_step_one: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FETCH |=> state_ff == S_IDLE && rv_ff) else $error("fetch lost");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rl_ff |-> !decoding_ff) else $error("block not ended");
endmodule
